>>> rtl/quoted_printable_line_encoder_defines.svh
// assertion macros for the quoted-printable line encoder
`ifndef QUOTED_PRINTABLE_LINE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_LINE_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define QPLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QPLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QPLE_ASSERT_IMP(lbl, ante, cons, msg)
`define QPLE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/qple_pkg.sv
// shared types and constants of the quoted-printable line encoder
`timescale 1ns / 1ps
`default_nettype none
package qple_pkg;

  localparam int unsigned MaxLine    = 76;
  localparam int unsigned StoreDepth = 128;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam logic [AddrW-1:0] MaxLineIdx = AddrW'(MaxLine);
  localparam logic [AddrW-1:0] BreakFill  = AddrW'(MaxLine + 2);

  localparam logic [7:0] ChEq  = 8'd61;
  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChSp  = 8'd32;

  typedef enum logic [3:0] {
    StIdle,
    StPush,
    StFlRd,
    StFlXfer,
    StBrRd,
    StBrChk,
    StBkRd,
    StBkXfer,
    StTail,
    StDone
  } qple_state_e;

  typedef struct packed {
    logic load;
    logic push;
    logic idx_inc;
    logic start_flush;
    logic start_brk;
    logic rd_k;
    logic rd_j;
    logic brk_chk;
    logic xfer;
    logic tail;
    logic flush_clr;
    logic commit;
    logic pk_final;
  } qple_cmd_t;

  typedef struct packed {
    logic flush_now;
    logic brk_now;
    logic idx_last;
    logic k_last;
    logic brk_found;
    logic tail_last;
    logic pk_ready;
    logic out_free;
    logic grp_empty;
  } qple_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'd48 + {4'd0, n}) : (8'd55 + {4'd0, n});
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    is_plain = (b >= 8'd33 && b <= 8'd60) || (b >= 8'd62 && b <= 8'd126) ||
               b == ChCr || b == ChLf || b == ChTab || b == ChSp;
  endfunction

endpackage
`default_nettype wire

>>> rtl/quoted_printable_line_encoder.sv
// top level of the quoted-printable line encoder
// usage
//   input channel: in_valid_i / in_ready_o carry one text byte with a final mark
//   output channel: out_valid_o / out_ready_i carry groups of up to four bytes,
//   byte_count_o says how many are valid, unused bytes read zero
//   run_end_o marks the last group caused by one request, text_end_o the last
//   group of the whole text; a request that yields no byte gives no group
// timing
//   one request at a time: in_ready_o is high only while the block is idle
//   a plain byte that only lands in the line passes idle, push and done; an escape
//   pushes its three bytes in turn; a flush or a soft break reads the line store
//   one byte at a time through a read and a transfer state (registered read port),
//   a break search uses a read and a check state per byte checked, and the soft-break
//   tail sends = CR LF; a byte transfer waits while a full group cannot leave
// reset
//   the line is emptied; the line store itself is not cleared
// back-pressure
//   a finished group waits in the output register while packing goes on;
//   the next full group stalls the block until out_ready_i takes the first
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_line_encoder_defines.svh"
module quoted_printable_line_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      byte_a_o,
  output logic [7:0]      byte_b_o,
  output logic [7:0]      byte_c_o,
  output logic [7:0]      byte_d_o,
  output logic [2:0]      byte_count_o,
  output logic            run_end_o,
  output logic            text_end_o
);
  import qple_pkg::*;

  qple_cmd_t  cmd;
  qple_stat_t st;

  // sequencer for push, flush, break search and tail
  qple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // line store, counters and output packer
  qple_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_a_o     (byte_a_o),
    .byte_b_o     (byte_b_o),
    .byte_c_o     (byte_c_o),
    .byte_d_o     (byte_d_o),
    .byte_count_o (byte_count_o),
    .run_end_o    (run_end_o),
    .text_end_o   (text_end_o)
  );

  // a group always holds between one and four bytes
  `QPLE_ASSERT_IMP(a_count_range, out_valid_o, byte_count_o != 3'd0 && byte_count_o <= 3'd4, "bad byte count")
  // end of text only on the closing group of a request
  `QPLE_ASSERT_IMP(a_text_end_run, out_valid_o && text_end_o, run_end_o, "text end without run end")
  // an accepted request keeps the block busy on the next cycle
  `QPLE_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready right after request")

endmodule
`default_nettype wire

>>> rtl/qple_ctrl.sv
// controller state machine of the quoted-printable line encoder
`timescale 1ns / 1ps
`default_nettype none
module qple_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire qple_pkg::qple_stat_t st_i,
  output qple_pkg::qple_cmd_t      cmd_o
);
  import qple_pkg::*;

  qple_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StPush;
      end
      StPush: begin
        if (st_i.flush_now) state_d = StFlRd;
        else if (st_i.brk_now) state_d = StBrRd;
        else if (st_i.idx_last) state_d = StDone;
      end
      StFlRd: state_d = StFlXfer;
      StFlXfer: begin
        if (st_i.pk_ready) begin
          if (!st_i.k_last) state_d = StFlRd;
          else if (st_i.idx_last) state_d = StDone;
          else state_d = StPush;
        end
      end
      StBrRd: state_d = StBrChk;
      StBrChk: state_d = st_i.brk_found ? StBkRd : StBrRd;
      StBkRd: state_d = StBkXfer;
      StBkXfer: begin
        if (st_i.pk_ready) state_d = st_i.k_last ? StTail : StBkRd;
      end
      StTail: begin
        if (st_i.pk_ready && st_i.tail_last) state_d = st_i.idx_last ? StDone : StPush;
      end
      StDone: begin
        if (st_i.grp_empty || st_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StPush: begin
        cmd_o.push = 1'b1;
        if (st_i.flush_now) cmd_o.start_flush = 1'b1;
        else if (st_i.brk_now) cmd_o.start_brk = 1'b1;
        else if (!st_i.idx_last) cmd_o.idx_inc = 1'b1;
      end
      StFlRd: cmd_o.rd_k = 1'b1;
      StFlXfer: begin
        if (st_i.pk_ready) begin
          cmd_o.xfer = 1'b1;
          if (st_i.k_last) begin
            cmd_o.flush_clr = 1'b1;
            cmd_o.idx_inc   = !st_i.idx_last;
          end
        end
      end
      StBrRd:  cmd_o.rd_j    = 1'b1;
      StBrChk: cmd_o.brk_chk = 1'b1;
      StBkRd:  cmd_o.rd_k    = 1'b1;
      StBkXfer: cmd_o.xfer   = st_i.pk_ready;
      StTail: begin
        if (st_i.pk_ready) begin
          cmd_o.tail = 1'b1;
          if (st_i.tail_last) begin
            cmd_o.commit  = 1'b1;
            cmd_o.idx_inc = !st_i.idx_last;
          end
        end
      end
      StDone: cmd_o.pk_final = !st_i.grp_empty && st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/qple_datapath.sv
// datapath: item encoding, line store, break search and output packing
`timescale 1ns / 1ps
`default_nettype none
module qple_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                final_byte_i,
  input  wire qple_pkg::qple_cmd_t cmd_i,
  output qple_pkg::qple_stat_t     st_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               byte_a_o,
  output logic [7:0]               byte_b_o,
  output logic [7:0]               byte_c_o,
  output logic [7:0]               byte_d_o,
  output logic [2:0]               byte_count_o,
  output logic                     run_end_o,
  output logic                     text_end_o
);
  import qple_pkg::*;

  // item registers
  logic [7:0]       enc_q [3];
  logic [1:0]       nlast_q, idx_q;
  logic             fin_q;
  // line store as a ring, head_q is the line start
  logic [7:0]       line_store_q [StoreDepth];
  logic [AddrW-1:0] head_q, fill_q, j_q, k_q, lim_q;
  logic [1:0]       t_q;
  logic [7:0]       rd_a_q, rd_b_q;
  // output packer
  logic [7:0]       grp_q [4];
  logic [2:0]       gcnt_q;
  logic             out_valid_q;
  logic [7:0]       out_b_q [4];
  logic [2:0]       out_cnt_q;
  logic             run_end_q, text_end_q;

  logic [7:0]       cur_byte, pk_byte, tail_byte;
  logic             cur_last, pk_push, out_free, ws, esc, in_word, found;
  logic [AddrW-1:0] fill_inc, jn, jsel, addr_a, addr_b;

  assign cur_byte = enc_q[idx_q];
  assign cur_last = fin_q && (idx_q == nlast_q);
  assign fill_inc = fill_q + AddrW'(1);

  // break search step
  assign ws      = (rd_a_q == ChSp) || (rd_a_q == ChTab);
  assign esc     = (j_q >= AddrW'(2)) && (rd_b_q == ChEq);
  assign in_word = !ws && !esc;
  assign jn      = in_word ? (j_q - AddrW'(1)) : j_q;
  assign found   = (jn == '0) || !in_word;
  assign jsel    = (jn == '0) ? MaxLineIdx : jn;

  assign addr_a = head_q + (cmd_i.rd_j ? j_q : k_q);
  assign addr_b = head_q + j_q - AddrW'(2);

  always_comb begin
    case (t_q)
      2'd0:    tail_byte = ChEq;
      2'd1:    tail_byte = ChCr;
      default: tail_byte = ChLf;
    endcase
  end

  assign pk_byte  = cmd_i.tail ? tail_byte : rd_a_q;
  assign pk_push  = cmd_i.xfer | cmd_i.tail;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    st_o.flush_now = (cur_byte == ChCr) || (cur_byte == ChLf) || cur_last;
    st_o.brk_now   = fill_inc >= BreakFill;
    st_o.idx_last  = idx_q == nlast_q;
    st_o.k_last    = (k_q + AddrW'(1)) == lim_q;
    st_o.brk_found = found;
    st_o.tail_last = t_q == 2'd2;
    st_o.pk_ready  = (gcnt_q != 3'd4) || out_free;
    st_o.out_free  = out_free;
    st_o.grp_empty = gcnt_q == 3'd0;
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fin_q <= final_byte_i;
      if (is_plain(text_byte_i)) begin
        enc_q[0] <= text_byte_i;
        nlast_q  <= 2'd0;
      end else begin
        enc_q[0] <= ChEq;
        nlast_q  <= 2'd2;
      end
      enc_q[1] <= hex_char(text_byte_i[7:4]);
      enc_q[2] <= hex_char(text_byte_i[3:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // line store, the fill stays below the depth since a break trims it first
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) line_store_q[head_q + fill_q] <= cur_byte;
    if (cmd_i.rd_k || cmd_i.rd_j) begin
      rd_a_q <= line_store_q[addr_a];
      rd_b_q <= line_store_q[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      j_q    <= '0;
      k_q    <= '0;
      lim_q  <= '0;
      t_q    <= '0;
    end else begin
      if (cmd_i.push) fill_q <= fill_inc;
      else if (cmd_i.flush_clr) fill_q <= '0;
      else if (cmd_i.commit) fill_q <= fill_q - lim_q;
      if (cmd_i.commit) head_q <= head_q + lim_q;
      if (cmd_i.start_flush) begin
        k_q   <= '0;
        lim_q <= fill_inc;
      end else if (cmd_i.start_brk) begin
        j_q <= fill_q;
      end else if (cmd_i.brk_chk) begin
        j_q <= found ? jsel : jn;
        if (found) begin
          k_q   <= '0;
          lim_q <= jsel + AddrW'(1);
        end
      end else if (cmd_i.xfer) begin
        k_q <= k_q + AddrW'(1);
      end
      if (cmd_i.commit) t_q <= '0;
      else if (cmd_i.tail) t_q <= t_q + 2'd1;
    end
  end

  // packer: a full group is held until the next byte shows it is not the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pk_push) begin
        gcnt_q <= (gcnt_q == 3'd4) ? 3'd1 : gcnt_q + 3'd1;
      end else if (cmd_i.pk_final) begin
        gcnt_q <= '0;
      end
      if ((pk_push && gcnt_q == 3'd4) || cmd_i.pk_final) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pk_push) begin
      if (gcnt_q == 3'd4) grp_q[0] <= pk_byte;
      else grp_q[gcnt_q[1:0]] <= pk_byte;
    end
    if ((pk_push && gcnt_q == 3'd4) || cmd_i.pk_final) begin
      for (int i = 0; i < 4; i++) begin
        out_b_q[i] <= (3'(i) < gcnt_q) ? grp_q[i] : 8'd0;
      end
      out_cnt_q  <= gcnt_q;
      run_end_q  <= cmd_i.pk_final;
      text_end_q <= cmd_i.pk_final && fin_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_a_o     = out_b_q[0];
  assign byte_b_o     = out_b_q[1];
  assign byte_c_o     = out_b_q[2];
  assign byte_d_o     = out_b_q[3];
  assign byte_count_o = out_cnt_q;
  assign run_end_o    = run_end_q;
  assign text_end_o   = text_end_q;

endmodule
`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for the quoted-printable line encoder
`timescale 1ns / 1ps
module tb;
  import qple_pkg::*;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_req_t;

  typedef struct packed {
    logic [7:0] b0, b1, b2, b3;
    logic [2:0] cnt;
    logic       run_last;
    logic       text_last;
  } qp_group_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] text_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] byte_a_o, byte_b_o, byte_c_o, byte_d_o;
  logic [2:0] byte_count_o;
  logic       run_end_o;
  logic       text_end_o;

  quoted_printable_line_encoder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .text_byte_i, .final_byte_i,
    .out_valid_o, .out_ready_i, .byte_a_o, .byte_b_o, .byte_c_o, .byte_d_o,
    .byte_count_o, .run_end_o, .text_end_o
  );

  // pending requests, filled by the stimulus block
  text_req_t pending_reqs[$];
  // groups the encoder should produce, oldest first
  qp_group_t expected_groups[$];
  int        error_count = 0;

  // shadow line of the encoder
  logic [7:0] shadow_line[StoreDepth];
  int         shadow_fill = 0;
  logic [7:0] emitted[$];

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void emit_byte(logic [7:0] b);
    emitted.insert(emitted.size(), b);
  endfunction

  // soft break: back up to whitespace or the end of an escape
  function automatic void break_line();
    int         j;
    int         rest;
    logic [7:0] c;
    logic       in_word;
    j = shadow_fill - 1;
    forever begin
      c = shadow_line[j];
      in_word = !(c == ChSp || c == ChTab) && !(j >= 2 && shadow_line[j-2] == ChEq);
      if (in_word) j--;
      if (j == 0) begin
        j = MaxLine;
        break;
      end
      if (!in_word) break;
    end
    for (int k = 0; k <= j; k++) emit_byte(shadow_line[k]);
    emit_byte(ChEq);
    emit_byte(ChCr);
    emit_byte(ChLf);
    rest = shadow_fill - (j + 1);
    for (int k = 0; k < rest; k++) shadow_line[k] = shadow_line[k + j + 1];
    shadow_fill = rest;
  endfunction

  function automatic void line_push(logic [7:0] b, logic last);
    if (shadow_fill < StoreDepth) begin
      shadow_line[shadow_fill] = b;
      shadow_fill++;
    end
    if (b == ChCr || b == ChLf || last) begin
      for (int k = 0; k < shadow_fill; k++) emit_byte(shadow_line[k]);
      shadow_fill = 0;
    end else if (shadow_fill >= MaxLine + 2) begin
      break_line();
    end
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 4'd10) ? 8'd48 + 8'(n) : 8'd55 + 8'(n);
  endfunction

  // encode one accepted request and queue the groups it yields
  function automatic void encode_request(text_req_t r);
    qp_group_t g;
    int        n;
    emitted.delete();
    if ((r.text >= 8'd33 && r.text <= 8'd60) || (r.text >= 8'd62 && r.text <= 8'd126) ||
        r.text == ChCr || r.text == ChLf || r.text == ChTab || r.text == ChSp) begin
      line_push(r.text, r.last);
    end else begin
      line_push(ChEq, 1'b0);
      line_push(hex_digit(r.text[7:4]), 1'b0);
      line_push(hex_digit(r.text[3:0]), r.last);
    end
    n = (emitted.size() + 3) / 4;
    for (int i = 0; i < n; i++) begin
      g = '0;
      g.cnt = 3'((emitted.size() - 4*i) > 4 ? 4 : emitted.size() - 4*i);
      g.b0 = emitted[4*i];
      if (g.cnt > 1) g.b1 = emitted[4*i+1];
      if (g.cnt > 2) g.b2 = emitted[4*i+2];
      if (g.cnt > 3) g.b3 = emitted[4*i+3];
      g.run_last  = (i == n - 1);
      g.text_last = (i == n - 1) && r.last;
      expected_groups.insert(expected_groups.size(), g);
    end
  endfunction

  // sender: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      text_byte_i  <= '0;
      final_byte_i <= 1'b0;
    end else begin
      text_req_t r;
      if (in_valid_i && in_ready_o) begin
        encode_request(pending_reqs.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs[0];
          in_valid_i   <= 1'b1;
          text_byte_i  <= r.text;
          final_byte_i <= r.last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: its own stall pattern plus one long hold-off
  int hold_cycles = 0;
  int cyc         = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      qp_group_t got, want;
      cyc++;
      if (out_valid_o && out_ready_i) begin
        got = '{byte_a_o, byte_b_o, byte_c_o, byte_d_o, byte_count_o, run_end_o,
                text_end_o};
        if (expected_groups.size() == 0) begin
          $display("%0t: unexpected group expected nothing actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_groups.pop_front();
          if (got !== want) begin
            $display("%0t: group mismatch expected %h actual %h", $time, want, got);
            error_count++;
          end
        end
      end
      if (cyc == 600) hold_cycles = 400;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if ((cyc / 500) % 3 == 2) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(3, 0) != 0);
      end
    end
  end

  task automatic add_req(logic [7:0] t, logic l);
    pending_reqs.insert(pending_reqs.size(), text_req_t'{t, l});
  endtask

  initial begin
    int len;
    int kind;
    rst_ni = 1'b0;
    // directed: extremes, whitespace, escapes, line ends, final mark
    add_req(8'h00, 0); add_req(8'hFF, 0); add_req(8'd61, 0); add_req(8'd33, 0);
    add_req(8'd126, 0); add_req(8'd127, 0); add_req(ChSp, 0); add_req(ChTab, 0);
    add_req(ChCr, 0); add_req(ChLf, 0); add_req(8'd60, 0); add_req(8'd62, 0);
    add_req(8'hA5, 1); add_req(8'h5A, 1);
    // long word with no whitespace forces a hard break
    for (int i = 0; i < 90; i++) add_req(8'd65 + 8'(i % 26), i == 89);
    // random texts: printable bytes, whitespace, line ends and escapes; long lines exercise soft breaks
    while (pending_reqs.size() < 470) begin
      len = $urandom_range(160, 1);
      if (len > 470 - pending_reqs.size()) len = 470 - pending_reqs.size();
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(19, 0);
        if (kind < 12) add_req(8'($urandom_range(126, 33)), i == len - 1);
        else if (kind < 15) add_req(($urandom_range(1, 0) ? ChSp : ChTab), i == len - 1);
        else if (kind == 15) add_req((($urandom_range(1, 0)) ? ChCr : ChLf), i == len - 1);
        else add_req(8'($urandom_range(255, 0)), i == len - 1);
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_groups.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_groups.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
